[src/dtpw_pkg.sv]
package dtpw_pkg;

  // Elaboration defaults
  localparam int MAX_DIM_DEFAULT = 512;

  // Blend table: one entry for every pair of fragment color and old byte
  localparam int BLEND_ENTRIES = 65536;
  localparam int BLEND_AW      = 16;

  // Linear store address before the wrap: y * pitch + x with 10-bit operands
  localparam int LIN_W = 20;

  // Width of the reported frame address
  localparam int SCREEN_ADDR_W = 18;

  // Result queue
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = 4;

  // Configuration port
  localparam int CFG_AW = 5;
  localparam logic [2:0] REG_TARGET_WIDTH  = 3'd0;
  localparam logic [2:0] REG_TARGET_HEIGHT = 3'd1;
  localparam logic [2:0] REG_VIEW_OFFSET_X = 3'd2;
  localparam logic [2:0] REG_VIEW_OFFSET_Y = 3'd3;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd4;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd5;
  localparam logic [2:0] REG_DEPTH_ONLY    = 3'd6;

  localparam logic [9:0] RST_TARGET_WIDTH  = 10'd320;
  localparam logic [9:0] RST_TARGET_HEIGHT = 10'd200;
  localparam logic [9:0] RST_SCREEN_WIDTH  = 10'd320;
  localparam logic [9:0] RST_SCREEN_HEIGHT = 10'd200;

  // Action codes
  localparam logic [1:0] ACT_OPAQUE      = 2'd0;
  localparam logic [1:0] ACT_TRANSLUCENT = 2'd1;
  localparam logic [1:0] ACT_LOAD        = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_OUT_TARGET   = 2'd1;
  localparam logic [1:0] ST_DEPTH_FAIL   = 2'd2;
  localparam logic [1:0] ST_OUT_SCREEN   = 2'd3;

  // Fragment as it travels down the pipeline after the bounds checks
  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  color;
    logic [31:0] fz;
    logic [15:0] tindex;
    logic [7:0]  tvalue;
    logic        in_target;
    logic        in_screen;
  } frag_t;

  // One result item
  typedef struct packed {
    logic [1:0]               status;
    logic                     written;
    logic [SCREEN_ADDR_W-1:0] saddr;
    logic [7:0]               cout;
  } result_t;

endpackage

[src/dtpw_ram.sv]
module dtpw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read-first: a read at the written address returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/dtpw_addr_mod.sv]
module dtpw_addr_mod #(
  parameter int MAX_DIM = dtpw_pkg::MAX_DIM_DEFAULT,
  parameter int AW      = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                       clk_i,
  input  logic [dtpw_pkg::LIN_W-1:0] lin_i,
  output logic [AW-1:0]              addr_o
);

  localparam int LIN_W       = dtpw_pkg::LIN_W;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int PROD_W      = LIN_W + 32;
  localparam longint unsigned RECIP = (64'd1 << 32) / STORE_DEPTH;
  localparam logic [31:0] RECIP_C = 32'(RECIP);
  localparam logic [31:0] DEPTH_C = 32'(STORE_DEPTH);

  logic [PROD_W-1:0] prod;
  logic [LIN_W-1:0]  quot_d, quot_q;
  logic [LIN_W-1:0]  lin1_q, lin2_q;
  logic [LIN_W-1:0]  qd_d, qd_q;
  logic [LIN_W-1:0]  rem, rem_fix;
  logic [AW-1:0]     addr_d, addr_q;

  // Quotient estimate by reciprocal, low by at most one
  assign prod   = PROD_W'(lin_i) * PROD_W'(RECIP_C);
  assign quot_d = prod[PROD_W-1:32];

  // quot * depth never exceeds the linear address
  assign qd_d = LIN_W'(quot_q * DEPTH_C);

  // One correction step brings the remainder below the depth
  always_comb begin
    rem     = lin2_q - qd_q;
    rem_fix = rem;
    if (32'(rem) >= DEPTH_C) begin
      rem_fix = rem - LIN_W'(DEPTH_C);
    end
    addr_d = AW'(rem_fix);
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    lin1_q <= lin_i;
    qd_q   <= qd_d;
    lin2_q <= lin1_q;
    addr_q <= addr_d;
  end

  assign addr_o = addr_q;

endmodule

[src/depth_tested_pixel_writer_top.sv]
// Depth-tested pixel writer. Each input item is an opaque draw, a translucent
// draw or a blend-table load, and each gives exactly one result item, in
// order. The block takes one item per cycle while in_stall_o is low; each
// item passes the address pipeline (multiply-add, wrap of the address by
// reciprocal and correction over three stages), the registered reads of the
// depth and frame memories and of the blend table ahead of the write back.
// Depth and frame accesses to the same entry by neighboring items are
// forwarded from the write-back stage and the stage behind it, so no item
// waits on another. Up to 16 accepted items may be in flight or queued at the
// output; outside the clearing pass in_stall_o rises only when 16 results
// are owed, so a stalled output does not hold back the input until that
// point. After reset the depth and frame memories are cleared one entry a
// cycle, all MAX_DIM*MAX_DIM entries (262144 at the default), while
// in_stall_o stays high; configuration writes are taken throughout. The
// blend table is not cleared: load an entry before a translucent draw reads
// it. Write configuration only while the block is idle.
module depth_tested_pixel_writer_top #(
  parameter int MAX_DIM = dtpw_pkg::MAX_DIM_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  action_i,
  input  logic signed [15:0]          pos_x_i,
  input  logic signed [15:0]          pos_y_i,
  input  logic [7:0]                  color_i,
  input  logic signed [31:0]          frag_depth_i,
  input  logic [15:0]                 table_index_i,
  input  logic [7:0]                  table_value_i,

  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic                        color_written_o,
  output logic [17:0]                 screen_addr_o,
  output logic [7:0]                  color_out_o,

  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dtpw_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LIN_W       = dtpw_pkg::LIN_W;
  localparam int CNT_W       = dtpw_pkg::FIFO_AW + 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [9:0] tw_q, th_q, sw_q, sh_q;
  logic [8:0] offx_q, offy_q;
  logic       depth_only_q;
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[dtpw_pkg::CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_q         <= dtpw_pkg::RST_TARGET_WIDTH;
      th_q         <= dtpw_pkg::RST_TARGET_HEIGHT;
      offx_q       <= '0;
      offy_q       <= '0;
      sw_q         <= dtpw_pkg::RST_SCREEN_WIDTH;
      sh_q         <= dtpw_pkg::RST_SCREEN_HEIGHT;
      depth_only_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        dtpw_pkg::REG_TARGET_WIDTH:  tw_q         <= pwdata[9:0];
        dtpw_pkg::REG_TARGET_HEIGHT: th_q         <= pwdata[9:0];
        dtpw_pkg::REG_VIEW_OFFSET_X: offx_q       <= pwdata[8:0];
        dtpw_pkg::REG_VIEW_OFFSET_Y: offy_q       <= pwdata[8:0];
        dtpw_pkg::REG_SCREEN_WIDTH:  sw_q         <= pwdata[9:0];
        dtpw_pkg::REG_SCREEN_HEIGHT: sh_q         <= pwdata[9:0];
        dtpw_pkg::REG_DEPTH_ONLY:    depth_only_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      dtpw_pkg::REG_TARGET_WIDTH:  prdata = 32'(tw_q);
      dtpw_pkg::REG_TARGET_HEIGHT: prdata = 32'(th_q);
      dtpw_pkg::REG_VIEW_OFFSET_X: prdata = 32'(offx_q);
      dtpw_pkg::REG_VIEW_OFFSET_Y: prdata = 32'(offy_q);
      dtpw_pkg::REG_SCREEN_WIDTH:  prdata = 32'(sw_q);
      dtpw_pkg::REG_SCREEN_HEIGHT: prdata = 32'(sh_q);
      dtpw_pkg::REG_DEPTH_ONLY:    prdata = 32'(depth_only_q);
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Clearing pass over the depth and frame memories after reset
  // ---------------------------------------------------------------------------
  logic              clearing_q;
  logic [ADDR_W-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      if (clr_addr_q == LAST_ADDR) begin
        clearing_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Credits: accepted items whose results are not yet taken
  // ---------------------------------------------------------------------------
  logic             in_acc, out_acc;
  logic [CNT_W-1:0] credit_q;

  assign in_stall_o = clearing_q || (credit_q == CNT_W'(dtpw_pkg::FIFO_DEPTH));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_q + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline valid bits, stages 1 to 7
  // ---------------------------------------------------------------------------
  logic [7:1] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[6:1], in_acc};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: bounds checks and linear addresses
  // ---------------------------------------------------------------------------
  logic [1:0]        s1_action_q;
  logic signed [15:0] s1_px_q, s1_py_q;
  logic [7:0]        s1_color_q;
  logic [31:0]       s1_fz_q;
  logic [15:0]       s1_tindex_q;
  logic [7:0]        s1_tvalue_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_action_q <= action_i;
      s1_px_q     <= pos_x_i;
      s1_py_q     <= pos_y_i;
      s1_color_q  <= color_i;
      s1_fz_q     <= frag_depth_i;
      s1_tindex_q <= table_index_i;
      s1_tvalue_q <= table_value_i;
    end
  end

  dtpw_pkg::frag_t  frag1;
  logic [10:0]      sx1, sy1;
  logic [LIN_W-1:0] lin_d1, lin_f1;

  always_comb begin
    // Screen position; only meaningful once the target test passes
    sx1 = 11'(s1_px_q[9:0]) + 11'(offx_q);
    sy1 = 11'(s1_py_q[9:0]) + 11'(offy_q);

    frag1.action    = s1_action_q;
    frag1.color     = s1_color_q;
    frag1.fz        = s1_fz_q;
    frag1.tindex    = s1_tindex_q;
    frag1.tvalue    = s1_tvalue_q;
    frag1.in_target = !s1_px_q[15] && !s1_py_q[15] &&
                      (s1_px_q[14:0] < 15'(tw_q)) && (s1_py_q[14:0] < 15'(th_q));
    frag1.in_screen = (sx1 < 11'(sw_q)) && (sy1 < 11'(sh_q));

    // Row times pitch plus column, before the wrap to the store depth
    lin_d1 = LIN_W'(s1_py_q[9:0]) * LIN_W'(tw_q) + LIN_W'(s1_px_q[9:0]);
    lin_f1 = LIN_W'(sy1[9:0]) * LIN_W'(sw_q) + LIN_W'(sx1[9:0]);
  end

  // ---------------------------------------------------------------------------
  // Stages 2 to 6: carry the fragment while the addresses wrap
  // ---------------------------------------------------------------------------
  dtpw_pkg::frag_t   frag_q [2:6];
  logic [LIN_W-1:0]  lin_d2_q, lin_f2_q;
  logic [ADDR_W-1:0] daddr5, faddr5;
  logic [ADDR_W-1:0] daddr6_q, faddr6_q;

  always_ff @(posedge clk_i) begin
    frag_q[2] <= frag1;
    frag_q[3] <= frag_q[2];
    frag_q[4] <= frag_q[3];
    frag_q[5] <= frag_q[4];
    frag_q[6] <= frag_q[5];
    lin_d2_q  <= lin_d1;
    lin_f2_q  <= lin_f1;
    daddr6_q  <= daddr5;
    faddr6_q  <= faddr5;
  end

  dtpw_addr_mod #(
    .MAX_DIM (MAX_DIM),
    .AW      (ADDR_W)
  ) u_daddr (
    .clk_i  (clk_i),
    .lin_i  (lin_d2_q),
    .addr_o (daddr5)
  );

  dtpw_addr_mod #(
    .MAX_DIM (MAX_DIM),
    .AW      (ADDR_W)
  ) u_faddr (
    .clk_i  (clk_i),
    .lin_i  (lin_f2_q),
    .addr_o (faddr5)
  );

  // ---------------------------------------------------------------------------
  // Memories: stage 5 reads depth and frame, stage 6 reads and loads the blend
  // table, stage 7 writes depth and frame back
  // ---------------------------------------------------------------------------
  logic [31:0]       depth_rd;
  logic [7:0]        frame_rd, blend_rd;
  logic              depth_we, frame_we;
  logic [ADDR_W-1:0] depth_wa, frame_wa;
  logic [31:0]       depth_wd;
  logic [7:0]        frame_wd;
  logic              blend_we;
  logic [dtpw_pkg::BLEND_AW-1:0] blend_ra;

  dtpw_ram #(
    .WIDTH (32),
    .DEPTH (STORE_DEPTH),
    .AW    (ADDR_W)
  ) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (depth_we),
    .waddr_i (depth_wa),
    .wdata_i (depth_wd),
    .raddr_i (daddr5),
    .rdata_o (depth_rd)
  );

  dtpw_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH),
    .AW    (ADDR_W)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (frame_we),
    .waddr_i (frame_wa),
    .wdata_i (frame_wd),
    .raddr_i (faddr5),
    .rdata_o (frame_rd)
  );

  dtpw_ram #(
    .WIDTH (8),
    .DEPTH (dtpw_pkg::BLEND_ENTRIES),
    .AW    (dtpw_pkg::BLEND_AW)
  ) u_blend_ram (
    .clk_i   (clk_i),
    .we_i    (blend_we),
    .waddr_i (frag_q[6].tindex),
    .wdata_i (frag_q[6].tvalue),
    .raddr_i (blend_ra),
    .rdata_o (blend_rd)
  );

  // ---------------------------------------------------------------------------
  // Stage 6: forward pending writes, depth test, pick the blend entry
  // ---------------------------------------------------------------------------
  logic [1:0]        st7_status_q;
  logic              pass7_q, dwe7_q, fwe7_q, trans7_q;
  logic [7:0]        color7_q;
  logic [31:0]       fz7_q;
  logic [ADDR_W-1:0] daddr7_q, faddr7_q;
  logic [7:0]        fdata7;

  logic              wr8_d_q, wr8_f_q;
  logic [ADDR_W-1:0] daddr8_q, faddr8_q;
  logic [31:0]       ddata8_q;
  logic [7:0]        fdata8_q;

  logic [31:0] depth_cur;
  logic [7:0]  frame_cur;
  logic        is_opaque6, is_trans6, depth_pass6, pass6;
  logic [1:0]  status6;

  always_comb begin
    // Stage 7 writes this cycle; stage 8 wrote at the edge of our read
    priority if (vld_q[7] && dwe7_q && (daddr7_q == daddr6_q)) begin
      depth_cur = fz7_q;
    end else if (wr8_d_q && (daddr8_q == daddr6_q)) begin
      depth_cur = ddata8_q;
    end else begin
      depth_cur = depth_rd;
    end

    priority if (vld_q[7] && fwe7_q && (faddr7_q == faddr6_q)) begin
      frame_cur = fdata7;
    end else if (wr8_f_q && (faddr8_q == faddr6_q)) begin
      frame_cur = fdata8_q;
    end else begin
      frame_cur = frame_rd;
    end

    is_opaque6  = frag_q[6].action == dtpw_pkg::ACT_OPAQUE;
    is_trans6   = frag_q[6].action == dtpw_pkg::ACT_TRANSLUCENT;
    depth_pass6 = $signed(frag_q[6].fz) > $signed(depth_cur);

    // Target test, then depth test, then screen test
    priority if (!(is_opaque6 || is_trans6)) begin
      status6 = dtpw_pkg::ST_OK;
    end else if (!frag_q[6].in_target) begin
      status6 = dtpw_pkg::ST_OUT_TARGET;
    end else if (is_opaque6 && !depth_pass6) begin
      status6 = dtpw_pkg::ST_DEPTH_FAIL;
    end else if (!frag_q[6].in_screen) begin
      status6 = dtpw_pkg::ST_OUT_SCREEN;
    end else begin
      status6 = dtpw_pkg::ST_OK;
    end

    pass6 = (is_opaque6 || is_trans6) && frag_q[6].in_target &&
            (is_trans6 || depth_pass6) && frag_q[6].in_screen;

    blend_ra = {frag_q[6].color, frame_cur};
    blend_we = vld_q[6] && (frag_q[6].action == dtpw_pkg::ACT_LOAD);
  end

  always_ff @(posedge clk_i) begin
    st7_status_q <= status6;
    pass7_q      <= pass6;
    dwe7_q       <= pass6 && is_opaque6;
    fwe7_q       <= pass6 && (is_trans6 || !depth_only_q);
    trans7_q     <= is_trans6;
    color7_q     <= frag_q[6].color;
    fz7_q        <= frag_q[6].fz;
    daddr7_q     <= daddr6_q;
    faddr7_q     <= faddr6_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 7: write back and build the result
  // ---------------------------------------------------------------------------
  assign fdata7 = trans7_q ? blend_rd : color7_q;

  always_comb begin
    if (clearing_q) begin
      depth_we = 1'b1;
      depth_wa = clr_addr_q;
      depth_wd = '0;
      frame_we = 1'b1;
      frame_wa = clr_addr_q;
      frame_wd = '0;
    end else begin
      depth_we = vld_q[7] && dwe7_q;
      depth_wa = daddr7_q;
      depth_wd = fz7_q;
      frame_we = vld_q[7] && fwe7_q;
      frame_wa = faddr7_q;
      frame_wd = fdata7;
    end
  end

  // Stage 8: remember the last writes for the forwarding path
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr8_d_q <= 1'b0;
      wr8_f_q <= 1'b0;
    end else begin
      wr8_d_q <= vld_q[7] && dwe7_q;
      wr8_f_q <= vld_q[7] && fwe7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    daddr8_q <= daddr7_q;
    faddr8_q <= faddr7_q;
    ddata8_q <= fz7_q;
    fdata8_q <= fdata7;
  end

  dtpw_pkg::result_t res7;
  logic [31:0]       faddr7_wide;

  assign faddr7_wide = 32'(faddr7_q);

  always_comb begin
    res7.status  = st7_status_q;
    res7.written = fwe7_q;
    res7.saddr   = pass7_q ? faddr7_wide[dtpw_pkg::SCREEN_ADDR_W-1:0] : '0;
    res7.cout    = fwe7_q ? fdata7 : '0;
  end

  // ---------------------------------------------------------------------------
  // Result queue; credits keep it from overflowing
  // ---------------------------------------------------------------------------
  dtpw_pkg::result_t             fifo_q [dtpw_pkg::FIFO_DEPTH];
  logic [dtpw_pkg::FIFO_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]              fifo_cnt_q;
  logic                          push;
  dtpw_pkg::result_t             head;

  assign push = vld_q[7];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + dtpw_pkg::FIFO_AW'(1);
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + dtpw_pkg::FIFO_AW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + CNT_W'(push) - CNT_W'(out_acc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res7;
    end
  end

  assign head            = fifo_q[rd_ptr_q];
  assign out_valid_o     = fifo_cnt_q != '0;
  assign status_o        = head.status;
  assign color_written_o = head.written;
  assign screen_addr_o   = head.saddr;
  assign color_out_o     = head.cout;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= CNT_W'(dtpw_pkg::FIFO_DEPTH))
    else $error("more items owed than the result queue holds");

  a_fifo_vs_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= credit_q)
    else $error("result queue holds more items than were accepted");

  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> (vld_q == '0))
    else $error("item in the pipeline during the clearing pass");

  a_written_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && color_written_o) |-> (status_o == dtpw_pkg::ST_OK))
    else $error("frame byte reported written for a rejected fragment");

endmodule

[sim/tb_depth_tested_pixel_writer_top.sv]
`timescale 1ns / 1ps

module tb_depth_tested_pixel_writer_top;

  // Store geometry at the default elaboration size
  localparam int STORE_WORDS = dtpw_pkg::MAX_DIM_DEFAULT * dtpw_pkg::MAX_DIM_DEFAULT;

  // Action code that the block must treat as a no-op
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Margin after the last owed result so the pipeline drains
  localparam int SETTLE_CYCLES = 12;
  // The clear pass after reset is quiet throughout; the limit outlasts it
  localparam int WATCHDOG_LIMIT = 1000000;
  // Long output hold-off, well past the 16 items the block can absorb
  localparam int HOLD_OFF_CYCLES = 120;

  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 95;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_EVERY_THIRD,
    STALL_HEAVY
  } stall_mode_e;

  typedef struct {
    logic [1:0]         action;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         color;
    logic signed [31:0] frag_depth;
    logic [15:0]        table_index;
    logic [7:0]         table_value;
  } frag_item_t;

  // Clock, reset and block ports; every input starts at a known value
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          action_i = '0;
  logic signed [15:0]  pos_x_i = '0;
  logic signed [15:0]  pos_y_i = '0;
  logic [7:0]          color_i = '0;
  logic signed [31:0]  frag_depth_i = '0;
  logic [15:0]         table_index_i = '0;
  logic [7:0]          table_value_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          status_o;
  logic                color_written_o;
  logic [17:0]         screen_addr_o;
  logic [7:0]          color_out_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [dtpw_pkg::CFG_AW-1:0] paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // Shadow of the block: registers, depth and frame stores, blend table
  int                  cfg_target_w;
  int                  cfg_target_h;
  int                  cfg_offset_x;
  int                  cfg_offset_y;
  int                  cfg_screen_w;
  int                  cfg_screen_h;
  bit                  cfg_depth_only;
  logic signed [31:0]  depth_mem [STORE_WORDS];
  logic [7:0]          frame_mem [STORE_WORDS];
  logic [7:0]          blend_mem [dtpw_pkg::BLEND_ENTRIES];
  bit                  blend_loaded [dtpw_pkg::BLEND_ENTRIES];

  // Fragments waiting for the driver, and results owed by the block in order
  frag_item_t          frag_queue [$];
  dtpw_pkg::result_t   owed_results [$];

  logic signed [15:0]  recent_x;
  logic signed [15:0]  recent_y;
  bit                  have_recent = 1'b0;

  int                  fail_count = 0;
  int                  quiet_cycles = 0;
  int                  hold_req_count = 0;

  depth_tested_pixel_writer_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .color_i         (color_i),
    .frag_depth_i    (frag_depth_i),
    .table_index_i   (table_index_i),
    .table_value_i   (table_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .color_written_o (color_written_o),
    .screen_addr_o   (screen_addr_o),
    .color_out_o     (color_out_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Map a fragment onto the target and the screen. Store addresses wrap to
  // 18 bits, which matters only when a pitch is set past MAX_DIM.
  function automatic void locate_frag(input frag_item_t f, output bit in_target,
                                      output bit in_screen, output logic [17:0] depth_addr,
                                      output logic [17:0] frame_addr);
    int px;
    int py;
    int sx;
    int sy;
    px = f.pos_x;
    py = f.pos_y;
    sx = px + cfg_offset_x;
    sy = py + cfg_offset_y;
    in_target  = px >= 0 && py >= 0 && px < cfg_target_w && py < cfg_target_h;
    in_screen  = sx < cfg_screen_w && sy < cfg_screen_h;
    depth_addr = 18'(py * cfg_target_w + px);
    frame_addr = 18'(sy * cfg_screen_w + sx);
  endfunction

  // Apply one fragment to the shadow stores and return the result it owes.
  // Order of tests: target bounds, depth (opaque only), screen bounds.
  function automatic dtpw_pkg::result_t predict_frag(input frag_item_t f);
    dtpw_pkg::result_t  r;
    bit                 in_target;
    bit                 in_screen;
    logic [17:0]        depth_addr;
    logic [17:0]        frame_addr;
    logic [7:0]         blended;
    r = '0;
    if (f.action == dtpw_pkg::ACT_LOAD) begin
      blend_mem[f.table_index]    = f.table_value;
      blend_loaded[f.table_index] = 1'b1;
    end else if (f.action == dtpw_pkg::ACT_OPAQUE ||
                 f.action == dtpw_pkg::ACT_TRANSLUCENT) begin
      locate_frag(f, in_target, in_screen, depth_addr, frame_addr);
      if (!in_target) begin
        r.status = dtpw_pkg::ST_OUT_TARGET;
      end else if (f.action == dtpw_pkg::ACT_OPAQUE &&
                   depth_mem[depth_addr] >= f.frag_depth) begin
        r.status = dtpw_pkg::ST_DEPTH_FAIL;
      end else if (!in_screen) begin
        r.status = dtpw_pkg::ST_OUT_SCREEN;
      end else begin
        r.status = dtpw_pkg::ST_OK;
        r.saddr  = frame_addr;
        if (f.action == dtpw_pkg::ACT_OPAQUE) begin
          depth_mem[depth_addr] = f.frag_depth;
          if (!cfg_depth_only) begin
            frame_mem[frame_addr] = f.color;
            r.written = 1'b1;
            r.cout    = f.color;
          end
        end else begin
          blended = blend_mem[{f.color, frame_mem[frame_addr]}];
          frame_mem[frame_addr] = blended;
          r.written = 1'b1;
          r.cout    = blended;
        end
      end
    end
    return r;
  endfunction

  // Queue a fragment and its result. A translucent draw that would read a
  // blend entry never loaded gets a load of that entry ahead of it.
  function automatic void queue_frag(input frag_item_t f);
    frag_item_t         entry_load;
    bit                 in_target;
    bit                 in_screen;
    logic [17:0]        depth_addr;
    logic [17:0]        frame_addr;
    logic [15:0]        blend_idx;
    if (f.action == dtpw_pkg::ACT_TRANSLUCENT) begin
      locate_frag(f, in_target, in_screen, depth_addr, frame_addr);
      blend_idx = {f.color, frame_mem[frame_addr]};
      if (in_target && in_screen && !blend_loaded[blend_idx]) begin
        entry_load             = f;
        entry_load.action      = dtpw_pkg::ACT_LOAD;
        entry_load.table_index = blend_idx;
        entry_load.table_value = 8'($urandom);
        frag_queue.push_back(entry_load);
        owed_results.push_back(predict_frag(entry_load));
      end
    end
    frag_queue.push_back(f);
    owed_results.push_back(predict_frag(f));
  endfunction

  function automatic frag_item_t make_frag(input logic [1:0] act, input int x, input int y,
                                           input logic [7:0] col, input logic [31:0] z,
                                           input logic [15:0] tidx, input logic [7:0] tval);
    frag_item_t f;
    f.action      = act;
    f.pos_x       = 16'(x);
    f.pos_y       = 16'(y);
    f.color       = col;
    f.frag_depth  = z;
    f.table_index = tidx;
    f.table_value = tval;
    return f;
  endfunction

  // Random fragment for the current setup: mostly inside the target, often
  // on the previous pixel so that depth tests and forwarding get exercised.
  function automatic frag_item_t random_frag();
    frag_item_t f;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      f.action = dtpw_pkg::ACT_OPAQUE;
    end else if (pick < 75) begin
      f.action = dtpw_pkg::ACT_TRANSLUCENT;
    end else if (pick < 93) begin
      f.action = dtpw_pkg::ACT_LOAD;
    end else begin
      f.action = ACT_UNUSED;
    end
    f.color       = 8'($urandom);
    f.table_index = 16'($urandom);
    f.table_value = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30 && have_recent) begin
      f.pos_x = recent_x;
      f.pos_y = recent_y;
    end else if (pick < 88) begin
      f.pos_x = 16'($urandom_range(0, cfg_target_w - 1));
      f.pos_y = 16'($urandom_range(0, cfg_target_h - 1));
    end else if (pick < 94) begin
      // Just outside one edge of the target
      f.pos_x = 16'($urandom_range(0, cfg_target_w - 1));
      f.pos_y = 16'($urandom_range(0, cfg_target_h - 1));
      case ($urandom_range(0, 3))
        0: f.pos_x = -16'sd1;
        1: f.pos_x = 16'(cfg_target_w);
        2: f.pos_y = -16'sd1;
        default: f.pos_y = 16'(cfg_target_h);
      endcase
    end else begin
      f.pos_x = 16'($urandom);
      f.pos_y = 16'($urandom);
    end
    recent_x    = f.pos_x;
    recent_y    = f.pos_y;
    have_recent = 1'b1;
    if ($urandom_range(0, 99) < 12) begin
      case ($urandom_range(0, 3))
        0: f.frag_depth = 32'h7FFF_FFFF;
        1: f.frag_depth = 32'h8000_0000;
        2: f.frag_depth = 32'h0000_0000;
        default: f.frag_depth = 32'hFFFF_FFFF;
      endcase
    end else begin
      f.frag_depth = $urandom;
    end
    return f;
  endfunction

  // One register write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [2:0] idx, input int value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= dtpw_pkg::CFG_AW'(4 * idx);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      dtpw_pkg::REG_TARGET_WIDTH:  cfg_target_w   = value & 'h3FF;
      dtpw_pkg::REG_TARGET_HEIGHT: cfg_target_h   = value & 'h3FF;
      dtpw_pkg::REG_VIEW_OFFSET_X: cfg_offset_x   = value & 'h1FF;
      dtpw_pkg::REG_VIEW_OFFSET_Y: cfg_offset_y   = value & 'h1FF;
      dtpw_pkg::REG_SCREEN_WIDTH:  cfg_screen_w   = value & 'h3FF;
      dtpw_pkg::REG_SCREEN_HEIGHT: cfg_screen_h   = value & 'h3FF;
      dtpw_pkg::REG_DEPTH_ONLY:    cfg_depth_only = value[0];
      default: ;
    endcase
  endtask

  // Write every register; return on a falling edge so queue updates never
  // share a time step with the driver
  task automatic apply_setup(input int tw, input int th, input int ox, input int oy,
                             input int sw, input int sh, input int depth_mode);
    write_reg(dtpw_pkg::REG_TARGET_WIDTH, tw);
    write_reg(dtpw_pkg::REG_TARGET_HEIGHT, th);
    write_reg(dtpw_pkg::REG_VIEW_OFFSET_X, ox);
    write_reg(dtpw_pkg::REG_VIEW_OFFSET_Y, oy);
    write_reg(dtpw_pkg::REG_SCREEN_WIDTH, sw);
    write_reg(dtpw_pkg::REG_SCREEN_HEIGHT, sh);
    write_reg(dtpw_pkg::REG_DEPTH_ONLY, depth_mode);
    @(negedge clk_i);
  endtask

  // Wait for every queued item to go out and every owed result to come back,
  // then let the pipeline drain past its latency
  task automatic wait_idle();
    while (frag_queue.size() != 0 || owed_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Stimulus sequence
  initial begin
    for (int i = 0; i < STORE_WORDS; i++) begin
      depth_mem[i] = '0;
      frame_mem[i] = '0;
    end
    for (int i = 0; i < dtpw_pkg::BLEND_ENTRIES; i++) blend_loaded[i] = 1'b0;
    cfg_target_w   = dtpw_pkg::RST_TARGET_WIDTH;
    cfg_target_h   = dtpw_pkg::RST_TARGET_HEIGHT;
    cfg_offset_x   = 0;
    cfg_offset_y   = 0;
    cfg_screen_w   = dtpw_pkg::RST_SCREEN_WIDTH;
    cfg_screen_h   = dtpw_pkg::RST_SCREEN_HEIGHT;
    cfg_depth_only = 1'b0;

    // Directed items under the reset setup: depth extremes, equal depth,
    // every target edge, loads at both ends of the table, the unused action
    queue_frag(make_frag(dtpw_pkg::ACT_OPAQUE, 0, 0, 8'hFF, 32'h0000_0001, 16'h0000, 8'h00));
    queue_frag(make_frag(dtpw_pkg::ACT_OPAQUE, 0, 0, 8'h00, 32'h0000_0001, 16'hFFFF, 8'hFF));
    queue_frag(make_frag(dtpw_pkg::ACT_OPAQUE, 0, 0, 8'h5A, 32'h7FFF_FFFF, 16'h1234, 8'hA5));
    queue_frag(make_frag(dtpw_pkg::ACT_OPAQUE, 319, 199, 8'h11, 32'h8000_0000, 16'h0, 8'h0));
    queue_frag(make_frag(dtpw_pkg::ACT_OPAQUE, 319, 199, 8'h22, 32'h0001_0000, 16'h0, 8'h0));
    queue_frag(make_frag(dtpw_pkg::ACT_OPAQUE, -1, 0, 8'h33, 32'h0001_0000, 16'h0, 8'h0));
    queue_frag(make_frag(dtpw_pkg::ACT_OPAQUE, 0, -32768, 8'h33, 32'h0001_0000, 16'h0, 8'h0));
    queue_frag(make_frag(dtpw_pkg::ACT_TRANSLUCENT, 32767, 0, 8'h33, 32'h0, 16'h0, 8'h0));
    queue_frag(make_frag(dtpw_pkg::ACT_OPAQUE, 320, 5, 8'h44, 32'h7FFF_FFFF, 16'h0, 8'h0));
    queue_frag(make_frag(dtpw_pkg::ACT_OPAQUE, 5, 200, 8'h44, 32'h7FFF_FFFF, 16'h0, 8'h0));
    queue_frag(make_frag(dtpw_pkg::ACT_LOAD, 0, 0, 8'h00, 32'h0, 16'hFFFF, 8'hFF));
    queue_frag(make_frag(dtpw_pkg::ACT_LOAD, 0, 0, 8'h00, 32'h0, 16'h0000, 8'h00));
    queue_frag(make_frag(dtpw_pkg::ACT_TRANSLUCENT, 0, 0, 8'hFF, 32'h0, 16'h0, 8'h0));
    queue_frag(make_frag(dtpw_pkg::ACT_TRANSLUCENT, 1, 1, 8'h00, 32'h0, 16'h0, 8'h0));
    queue_frag(make_frag(ACT_UNUSED, -1, -1, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));

    // Hold reset, then release it on a clock edge; the clear pass follows
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    // Depth-only mode and a window that hangs off the screen
    apply_setup(64, 64, 300, 190, 320, 200, 1);
    queue_frag(make_frag(dtpw_pkg::ACT_OPAQUE, 10, 5, 8'h77, 32'h0000_0005, 16'h0, 8'h0));
    queue_frag(make_frag(dtpw_pkg::ACT_OPAQUE, 10, 5, 8'h78, 32'h0000_0005, 16'h0, 8'h0));
    queue_frag(make_frag(dtpw_pkg::ACT_OPAQUE, 30, 5, 8'h79, 32'h0000_0005, 16'h0, 8'h0));
    queue_frag(make_frag(dtpw_pkg::ACT_TRANSLUCENT, 5, 20, 8'h7A, 32'h0, 16'h0, 8'h0));
    queue_frag(make_frag(dtpw_pkg::ACT_TRANSLUCENT, 10, 5, 8'h7B, 32'h0, 16'h0, 8'h0));
    wait_idle();

    // Random phases: largest and smallest sizes, tiny targets for dense
    // collisions, a pitch past MAX_DIM so addresses wrap, then random setups
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: apply_setup(512, 512, 0, 0, 512, 512, 0);
        1: apply_setup(1, 1, 511, 511, 512, 512, 0);
        2: apply_setup(4, 4, 2, 1, 5, 5, 0);
        3: apply_setup(8, 3, 0, 0, 8, 3, 1);
        4: apply_setup(1023, 1023, 0, 0, 1023, 1023, 0);
        5: apply_setup(16, 16, 0, 0, 1, 1, 0);
        default: apply_setup($urandom_range(1, 512), $urandom_range(1, 512),
                             $urandom_range(0, 511), $urandom_range(0, 511),
                             $urandom_range(1, 512), $urandom_range(1, 512),
                             $urandom_range(0, 1));
      endcase
      // Ask the receiver for a long hold-off so the block fills and stalls
      if (p == 2 || p == 6) hold_req_count++;
      repeat (ITEMS_PER_PHASE) queue_frag(random_frag());
      wait_idle();
    end

    if (fail_count == 0 && owed_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Driver: present items in bursts with random gaps, hold while stalled
  frag_item_t drive_item;
  int         burst_left = 0;
  int         gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left > 0 || frag_queue.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        drive_item = frag_queue.pop_front();
        in_valid_i    <= 1'b1;
        action_i      <= drive_item.action;
        pos_x_i       <= drive_item.pos_x;
        pos_y_i       <= drive_item.pos_y;
        color_i       <= drive_item.color;
        frag_depth_i  <= drive_item.frag_depth;
        table_index_i <= drive_item.table_index;
        table_value_i <= drive_item.table_value;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Receiver stall: switch among patterns over random spans; on request,
  // hold off for a long stretch counted here
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_span = 0;
  int          stall_tick = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (hold_seen != hold_req_count) begin
        hold_seen = hold_req_count;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (stall_span == 0) begin
          stall_mode = stall_mode_e'($urandom_range(0, 3));
          stall_span = $urandom_range(8, 60);
        end else begin
          stall_span--;
        end
        stall_tick++;
        case (stall_mode)
          STALL_NONE:        out_stall_i <= 1'b0;
          STALL_COIN:        out_stall_i <= 1'($urandom_range(0, 1));
          STALL_EVERY_THIRD: out_stall_i <= (stall_tick % 3 == 0);
          default:           out_stall_i <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // Monitor: compare each accepted result with the oldest owed one
  dtpw_pkg::result_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected result: status=%0d written=%0d addr=%0h color=%0h",
                   status_o, color_written_o, screen_addr_o, color_out_o);
        end
      end else begin
        want = owed_results.pop_front();
        if (status_o !== want.status || color_written_o !== want.written ||
            screen_addr_o !== want.saddr || color_out_o !== want.cout) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: status %0d/%0d written %0d/%0d addr %0h/%0h color %0h/%0h",
                     want.status, status_o, want.written, color_written_o,
                     want.saddr, screen_addr_o, want.cout, color_out_o);
          end
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
